// File: design/refcounted_bitmap_frame_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the refcounted bitmap frame allocator
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define RBFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbfa assertion failed");

// next-cycle implication
`define RBFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbfa assertion failed");

`endif

// File: design/rbfa_pkg.sv
// ----------------------------------------------------------------------------
// rbfa_pkg
// Shared constants, types and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package rbfa_pkg;

    localparam int MAX_FRAMES_DEF = 4096;
    localparam int ADDR_W         = 48;
    localparam int CNT_W          = 13;
    localparam int FRAME_SHIFT    = 12;
    localparam int WORD_SHIFT     = 6;
    localparam int WORD_BITS      = 64;
    localparam int SCAN_W         = CNT_W - WORD_SHIFT;
    localparam int RESERVE_RESET  = 5;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_BASE  = 2'd0;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
    localparam logic [1:0] REG_RESERVE     = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAME  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_base;
        logic [CNT_W-1:0]  eff_count;
        logic [CNT_W-1:0]  reserve;
        logic              reinit;
        logic [CNT_W-1:0]  reinit_count;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  free_frames;
        t_status           status;
        logic [ADDR_W-1:0] granted_address;
    } t_result;

    // position of the lowest set bit (0 when none)
    function automatic logic [WORD_SHIFT-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_SHIFT-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) pos = WORD_SHIFT'(i);
        end
        return pos;
    endfunction

endpackage

// File: design/rbfa_bitmap.sv
// ----------------------------------------------------------------------------
// rbfa_bitmap
// Used-bitmap word memory, one write and one registered read port, with a
// zeroing sweep after reset and on request.
// ----------------------------------------------------------------------------
module rbfa_bitmap
    import rbfa_pkg::*;
#(
    parameter int NUM_WORDS = MAX_FRAMES_DEF / WORD_BITS,
    parameter int WW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    output logic                 o_busy,
    input  logic                 i_rd_en,
    input  logic [WW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [WW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [WW-1:0]        r_clr_ptr;
    logic                 r_clearing;

    logic                 m_we;
    logic [WW-1:0]        m_waddr;
    logic [WORD_BITS-1:0] m_wdata;

    assign m_we    = r_clearing || i_wr_en;
    assign m_waddr = r_clearing ? r_clr_ptr : i_wr_addr;
    assign m_wdata = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_clearing <= 1'b1;
            r_clr_ptr  <= '0;
        end else if (r_clearing) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
            if (r_clr_ptr == WW'(NUM_WORDS - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_waddr] <= m_wdata;
        if (i_rd_en) r_rd_data <= mem[i_rd_addr];
    end

    assign o_busy    = r_clearing;
    assign o_rd_data = r_rd_data;

endmodule

// File: design/rbfa_ctrl.sv
// ----------------------------------------------------------------------------
// rbfa_ctrl
// Request sequencer: word scan for allocation, range check and bit clear
// for free, free counter, output register.
// ----------------------------------------------------------------------------
`include "refcounted_bitmap_frame_allocator_top_defines.svh"

module rbfa_ctrl
    import rbfa_pkg::*;
#(
    parameter int WW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_busy,
    // request
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic                 i_s_cmd,
    input  logic [ADDR_W-1:0]    i_s_addr,
    // response
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output t_result              o_m_result,
    // bitmap memory
    output logic                 o_rd_en,
    output logic [WW-1:0]        o_rd_addr,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output logic                 o_wr_en,
    output logic [WW-1:0]        o_wr_addr,
    output logic [WORD_BITS-1:0] o_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_CHK,
        S_FREE_RD,
        S_SCAN,
        S_GRANT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [CNT_W-1:0]      r_idx;
    logic [SCAN_W-1:0]     r_rd_ptr;
    logic                  r_dvalid;
    logic [SCAN_W-1:0]     r_dword;
    logic [CNT_W-1:0]      r_free;
    t_status               r_status;
    logic [ADDR_W-1:0]     r_granted;
    logic                  r_out_valid;
    t_result               r_out;

    logic [SCAN_W-1:0]     nwords;
    logic [ADDR_W:0]       diff;
    logic [CNT_W-1:0]      diff_idx;
    logic                  in_range;
    logic [WORD_BITS-1:0]  free_mask;
    logic                  found;
    logic [WORD_SHIFT-1:0] low_bit;
    logic                  bit_set;
    logic                  scan_rd;
    logic                  accept;

    assign nwords    = i_cfg.eff_count[CNT_W-1:WORD_SHIFT];
    assign diff      = {1'b0, r_addr} - {1'b0, i_cfg.frame_base};
    assign diff_idx  = diff[FRAME_SHIFT +: CNT_W];
    assign in_range  = !diff[ADDR_W] &&
                       (diff[ADDR_W-1:FRAME_SHIFT] < (ADDR_W - FRAME_SHIFT)'(i_cfg.eff_count));
    assign free_mask = ~i_rd_data;
    assign found     = |free_mask;
    assign low_bit   = lowest_one(free_mask);
    assign bit_set   = i_rd_data[r_idx[WORD_SHIFT-1:0]];

    assign scan_rd   = (r_state == S_SCAN) && (r_rd_ptr < nwords);
    assign o_rd_en   = scan_rd || ((r_state == S_FREE_CHK) && in_range);
    assign o_rd_addr = scan_rd ? WW'(r_rd_ptr) : WW'(diff_idx[CNT_W-1:WORD_SHIFT]);

    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = WW'(r_idx[CNT_W-1:WORD_SHIFT]);
        o_wr_data = i_rd_data & ~(WORD_BITS'(1) << r_idx[WORD_SHIFT-1:0]);
        if (r_state == S_SCAN) begin
            o_wr_en   = r_dvalid && found;
            o_wr_addr = WW'(r_dword);
            o_wr_data = i_rd_data | (WORD_BITS'(1) << low_bit);
        end else if (r_state == S_FREE_RD) begin
            o_wr_en   = bit_set;
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !i_busy;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= '0;
            r_dvalid    <= 1'b0;
        end else begin
            r_dvalid <= scan_rd;
            r_dword  <= r_rd_ptr;
            if (scan_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            // in S_DONE the load below decides the valid flag
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) r_out_valid <= 1'b0;
            if (i_cfg.reinit) r_free <= i_cfg.reinit_count;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_addr    <= i_s_addr;
                        r_granted <= '0;
                        if (i_s_cmd == CMD_FREE) begin
                            r_state <= S_FREE_CHK;
                        end else if ((r_free > i_cfg.reserve) && (nwords != '0)) begin
                            r_rd_ptr <= '0;
                            r_state  <= S_SCAN;
                        end else begin
                            r_status <= ST_NO_FRAME;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_FREE_CHK: begin
                    if (in_range) begin
                        r_idx   <= diff_idx;
                        r_state <= S_FREE_RD;
                    end else begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end
                end
                S_FREE_RD: begin
                    // a frame is owned exactly while its bit is set
                    if (bit_set) begin
                        r_free   <= r_free + 1'b1;
                        r_status <= ST_OK;
                    end else begin
                        r_status <= ST_NOT_ALLOC;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (r_dvalid) begin
                        if (found) begin
                            r_idx   <= {r_dword, low_bit};
                            r_free  <= r_free - 1'b1;
                            r_state <= S_GRANT;
                        end else if (r_dword == nwords - 1'b1) begin
                            r_status <= ST_NO_FRAME;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_GRANT: begin
                    r_granted <= i_cfg.frame_base + ADDR_W'({r_idx, {FRAME_SHIFT{1'b0}}});
                    r_status  <= ST_OK;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid           <= 1'b1;
                        r_out.granted_address <= r_granted;
                        r_out.status          <= r_status;
                        r_out.free_frames     <= r_free;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_result = r_out;

    `RBFA_ASSERT_IMP(a_no_write_in_clear, o_wr_en, !i_busy)
    `RBFA_ASSERT_IMP(a_free_bounded, 1'b1, r_free <= i_cfg.eff_count)
    `RBFA_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE)
    `RBFA_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule

// File: design/refcounted_bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// refcounted_bitmap_frame_allocator_top
// 4 KiB physical frame allocator: used bitmap in memory, free counter,
// reserve check, range-checked free.
// ----------------------------------------------------------------------------
// Usage:
//  - Request stream (s_axis): tuser = command (0 allocate, 1 free),
//    tdata = frame address to free (ignored on allocate).
//  - Response stream (m_axis): one response per request, in order, with the
//    granted address, status and free frame count after the request.
//  - Config port: write enable, index (0 frame_base, 1 frame_count,
//    2 reserve_frames), data. Write only while no request is in flight.
//    Writing frame_count clears the bitmap and reloads the free counter.
//  - An allocate scans one 64-frame bitmap word per cycle through the
//    single memory read port, and is refused at once when the reserve (or
//    a count below one whole word) does not allow it.
//  - One request at a time; the next is accepted while a response still
//    waits in the output register. A stalled receiver holds the response
//    and blocks only the completion of the following request.
//  - Reset and frame_count writes start a zeroing sweep of the bitmap,
//    MAX_FRAMES/64 words (64 at default), during which tready is low.
//  - Reference counts never exceed one (a frame is granted only while its
//    bit is clear), so the used bit carries the count.
// ----------------------------------------------------------------------------
module refcounted_bitmap_frame_allocator_top
    import rbfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [47:0]       i_s_axis_tdata,  // [47:0] frame_address
    input  logic [0:0]        i_s_axis_tuser,  // [0] command
    // response stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,  // [47:0] granted_address,
                                               // [49:48] status,
                                               // [62:50] free_frames
    // configuration
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [ADDR_W-1:0] i_cfg_wdata
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // managed count is frame_count clamped to the bitmap size
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        return (32'(v) >= 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : v;
    endfunction

    logic [ADDR_W-1:0]    r_frame_base;
    logic [CNT_W-1:0]     r_frame_count;
    logic [CNT_W-1:0]     r_reserve;

    t_cfg                 cfg;
    t_result              result;
    logic                 busy;
    logic                 rd_en;
    logic [WW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base  <= '0;
            r_frame_count <= '0;
            r_reserve     <= CNT_W'(RESERVE_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_BASE:  r_frame_base  <= i_cfg_wdata;
                REG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[CNT_W-1:0];
                REG_RESERVE:     r_reserve     <= i_cfg_wdata[CNT_W-1:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    always_comb begin
        cfg.frame_base   = r_frame_base;
        cfg.eff_count    = clamp_count(r_frame_count);
        cfg.reserve      = r_reserve;
        cfg.reinit       = i_cfg_we && (i_cfg_idx == REG_FRAME_COUNT);
        cfg.reinit_count = clamp_count(i_cfg_wdata[CNT_W-1:0]);
    end

    rbfa_bitmap #(
        .NUM_WORDS (NUM_WORDS),
        .WW        (WW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg.reinit),
        .o_busy    (busy),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    rbfa_ctrl #(
        .WW (WW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_busy     (busy),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_cmd    (i_s_axis_tuser[0]),
        .i_s_addr   (i_s_axis_tdata),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_result (result),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    assign o_m_axis_tdata = {1'b0, result.free_frames, result.status, result.granted_address};

endmodule
